// ===== hdl/tbh_pkg.sv =====
// Shared types and constants for the two-bit level histogram.
`default_nettype none
package tbh_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int NUM_LANES       = 4;   // one lane per byte of the word
	localparam int FIELDS_PER_LANE = 4;
	localparam int NUM_LEVELS      = 4;
	localparam int NUM_STREAMS     = 16;
	localparam int NUM_CNT         = NUM_STREAMS * NUM_LEVELS;
	localparam int INC_W           = 4;   // up to eight samples per counter per word
	localparam int REM_W           = $clog2(NUM_CNT + 1);
	localparam int POS_W           = $clog2(NUM_CNT);
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;
	localparam int OUT_COUNT_W     = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_STREAM_MODE = 1'b0;

	typedef enum logic [1:0] {
		MODE_2  = 2'd0,
		MODE_4  = 2'd1,
		MODE_8  = 2'd2,
		MODE_16 = 2'd3
	} stream_mode_t;

	localparam logic [1:0] LEVEL_TOP = 2'd3;

	typedef struct packed {
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
		logic       end_of_period;
	} sample_t;

	typedef struct packed {
		logic [3:0]             stream_index;
		logic [1:0]             level;
		logic [OUT_COUNT_W-1:0] count;
		logic                   last_of_dump;
	} result_t;

	// Per-byte level counts: [field][level], [pair][level], [level]
	typedef struct packed {
		logic [FIELDS_PER_LANE-1:0][NUM_LEVELS-1:0]      field_hot;
		logic [1:0][NUM_LEVELS-1:0][1:0]                 pair_cnt;
		logic [NUM_LEVELS-1:0][2:0]                      byte_cnt;
	} lane_cnt_t;

	typedef struct packed {
		logic valid;
		logic eop;
	} stage_ctl_t;

	typedef logic [NUM_CNT-1:0][INC_W-1:0]       inc_vec_t;
	typedef logic [NUM_CNT-1:0][OUT_COUNT_W-1:0] snap_vec_t;

endpackage
`default_nettype wire

// ===== hdl/two_bit_level_histogram.sv =====
// Top level of the two-bit sample level histogram.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample): one word of sixteen
//   2-bit samples per cycle while sample_ready is high, plus end_of_period on
//   the period's last word. result channel (result_valid/result_ready/result):
//   after a period ends, one word per (stream, level) of the active streams,
//   streams in order and levels 0..3 within each, last_of_dump set on the final one.
//   APB port: register 0 (stream_mode) at byte address 0; write only while idle.
// Timing:
//   Words are taken one per cycle unless the pipe stalls. A word passes the
//   lane decode (stage 1) and the merge stage (stage 2), then updates the
//   counters; an end_of_period word also loads the dump line, whose first
//   count is registered in the result register. A dump emits 4 * streams words
//   (8 to 64), one per cycle while the receiver takes them. Counters are snapshot
//   into the dump line and cleared at once, so the next period keeps counting
//   during the dump. A second end_of_period word waits in stage 2, holding
//   sample_ready low, until the dump line has drained. A stalled receiver holds
//   the result register and the dump line; input keeps flowing until that point.
// Reset: all counters clear, stream_mode returns to 2 streams, no result valid.
`default_nettype none
module two_bit_level_histogram #(
	parameter int COUNT_WIDTH = tbh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  wire tbh_pkg::sample_t                  sample,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output tbh_pkg::result_t                       result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tbh_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [tbh_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tbh_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import tbh_pkg::*;

	stream_mode_t mode_q;
	sample_t      word_s1;
	stage_ctl_t   ctl_s1;
	stage_ctl_t   ctl_s2;
	inc_vec_t     inc_s2;
	snap_vec_t    snap;
	lane_cnt_t [NUM_LANES-1:0] lanes;
	logic         dump_busy;
	logic         stall;
	logic         advance;
	logic         dump_load;

	// Configuration port: pready is always high, register index on paddr[2]
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_2;
		end else if (psel && penable && pwrite && (paddr[2] == REG_STREAM_MODE)) begin
			mode_q <= stream_mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_STREAM_MODE) begin
			prdata = APB_DATA_W'(mode_q);
		end
	end

	// Hold the whole pipe only when a period end meets a dump still in progress
	assign stall        = ctl_s2.valid && ctl_s2.eop && dump_busy;
	assign advance      = !stall;
	assign sample_ready = advance;
	assign dump_load    = ctl_s2.valid && ctl_s2.eop && advance;

	// Stage 1: register the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid <= sample_valid;
			ctl_s1.eop   <= sample.end_of_period;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1 <= sample;
		end
	end

	// Byte lanes
	tbh_lane u_lane_0 (.lane_byte(word_s1.byte_0), .lane_cnt(lanes[0]));
	tbh_lane u_lane_1 (.lane_byte(word_s1.byte_1), .lane_cnt(lanes[1]));
	tbh_lane u_lane_2 (.lane_byte(word_s1.byte_2), .lane_cnt(lanes[2]));
	tbh_lane u_lane_3 (.lane_byte(word_s1.byte_3), .lane_cnt(lanes[3]));

	// Stage 2: per-counter increments for the current stream split
	tbh_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mode    (mode_q),
		.ctl_s1  (ctl_s1),
		.lanes   (lanes),
		.ctl_s2  (ctl_s2),
		.inc_s2  (inc_s2)
	);

	// Counters: add the word, then clear on a period end
	tbh_counters #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.update (ctl_s2.valid && advance),
		.clear  (ctl_s2.eop),
		.inc    (inc_s2),
		.snap   (snap)
	);

	// Dump line and result register
	tbh_dump u_dump (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (dump_load),
		.mode         (mode_q),
		.snap         (snap),
		.busy         (dump_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// The final word of a dump names the last active stream at the top level
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_of_dump) |->
			(result.level == LEVEL_TOP) &&
			(result.stream_index == 4'((2 << mode_q) - 1)))
		else $error("dump ended on the wrong stream or level");

	// Counters start over right after their snapshot is taken
	a_clear_after_dump: assert property (@(posedge clk) disable iff (!arst_n)
		dump_load |=> (u_counters.cnt_q == '0))
		else $error("counters not cleared after dump");

	// A new dump never loads over one still draining
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_busy && !$past(dump_load)) |-> !dump_load)
		else $error("dump loaded while busy");
`endif

endmodule
`default_nettype wire

// ===== hdl/tbh_lane.sv =====
// One byte lane: decode four 2-bit samples and count levels per pair and per byte.
`default_nettype none
module tbh_lane (
	input  wire logic [7:0]        lane_byte,
	output tbh_pkg::lane_cnt_t     lane_cnt
);
	import tbh_pkg::*;

	always_comb begin
		lane_cnt = '0;
		for (int p = 0; p < FIELDS_PER_LANE; p++) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				lane_cnt.field_hot[p][l] = (lane_byte[7 - 2*p -: 2] == 2'(l));
			end
		end
		for (int j = 0; j < 2; j++) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				lane_cnt.pair_cnt[j][l] = 2'(lane_cnt.field_hot[2*j][l])
					+ 2'(lane_cnt.field_hot[2*j+1][l]);
			end
		end
		for (int l = 0; l < NUM_LEVELS; l++) begin
			lane_cnt.byte_cnt[l] = 3'(lane_cnt.pair_cnt[0][l]) + 3'(lane_cnt.pair_cnt[1][l]);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/tbh_merge.sv =====
// Merge stage: combine lane counts into per-counter increments for the stream mode.
`default_nettype none
module tbh_merge (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      advance,
	input  wire tbh_pkg::stream_mode_t                     mode,
	input  wire tbh_pkg::stage_ctl_t                       ctl_s1,
	input  wire tbh_pkg::lane_cnt_t [tbh_pkg::NUM_LANES-1:0] lanes,
	output tbh_pkg::stage_ctl_t                            ctl_s2,
	output tbh_pkg::inc_vec_t                              inc_s2
);
	import tbh_pkg::*;

	inc_vec_t inc_d;

	for (genvar s = 0; s < NUM_STREAMS; s++) begin : gen_s
		for (genvar l = 0; l < NUM_LEVELS; l++) begin : gen_l
			logic [INC_W-1:0] v16, v8, v4, v2, inc_sel;

			assign v16 = INC_W'(lanes[s/4].field_hot[s%4][l]);
			if (s < 8) begin : gen_v8
				assign v8 = INC_W'(lanes[s/2].pair_cnt[s%2][l]);
			end else begin : gen_v8_off
				assign v8 = '0;
			end
			if (s < 4) begin : gen_v4
				assign v4 = INC_W'(lanes[s].byte_cnt[l]);
			end else begin : gen_v4_off
				assign v4 = '0;
			end
			if (s < 2) begin : gen_v2
				assign v2 = INC_W'(lanes[2*s].byte_cnt[l]) + INC_W'(lanes[2*s+1].byte_cnt[l]);
			end else begin : gen_v2_off
				assign v2 = '0;
			end

			always_comb begin
				unique case (mode)
					MODE_2:  inc_sel = v2;
					MODE_4:  inc_sel = v4;
					MODE_8:  inc_sel = v8;
					MODE_16: inc_sel = v16;
					default: inc_sel = '0;
				endcase
			end

			assign inc_d[s*NUM_LEVELS + l] = inc_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inc_s2 <= inc_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/tbh_counters.sv =====
// Bank of saturating level counters with clear on dump.
`default_nettype none
module tbh_counters #(
	parameter int COUNT_WIDTH = tbh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              update,
	input  wire logic              clear,
	input  wire tbh_pkg::inc_vec_t inc,
	output tbh_pkg::snap_vec_t     snap
);
	import tbh_pkg::*;

	logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt_q;
	logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt_sum;

	always_comb begin
		for (int i = 0; i < NUM_CNT; i++) begin
			logic [COUNT_WIDTH:0] wide;
			wide = {1'b0, cnt_q[i]} + (COUNT_WIDTH+1)'(inc[i]);
			cnt_sum[i] = wide[COUNT_WIDTH] ? '1 : wide[COUNT_WIDTH-1:0];
		end
	end

	// Clamp to the 32-bit report field
	for (genvar i = 0; i < NUM_CNT; i++) begin : gen_snap
		if (COUNT_WIDTH > OUT_COUNT_W) begin : gen_clamp
			assign snap[i] = (|cnt_sum[i][COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
				: cnt_sum[i][OUT_COUNT_W-1:0];
		end else begin : gen_ext
			assign snap[i] = OUT_COUNT_W'(cnt_sum[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (update) begin
			if (clear) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_sum;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/tbh_dump.sv =====
// Dump line: hold a snapshot of counts; shift out one word a cycle while taken.
`default_nettype none
module tbh_dump (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire tbh_pkg::stream_mode_t mode,
	input  wire tbh_pkg::snap_vec_t    snap,
	output logic                       busy,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output tbh_pkg::result_t           result
);
	import tbh_pkg::*;

	snap_vec_t        line_q;
	logic [REM_W-1:0] rem_q;
	logic [POS_W-1:0] pos_q;
	logic             take;

	assign busy = (rem_q != '0);
	assign take = busy && (!result_valid || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q        <= '0;
			pos_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (load) begin
				rem_q <= REM_W'(2 * NUM_LEVELS) << mode;
				pos_q <= '0;
			end else if (take) begin
				rem_q <= rem_q - REM_W'(1);
				pos_q <= pos_q + POS_W'(1);
			end
			if (take) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_q <= snap;
		end else if (take) begin
			for (int i = 0; i < NUM_CNT - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
		end
		if (take) begin
			result.stream_index <= pos_q[POS_W-1:2];
			result.level        <= pos_q[1:0];
			result.count        <= line_q[0];
			result.last_of_dump <= (rem_q == REM_W'(1));
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_two_bit_level_histogram.sv =====
// Self-checking testbench for the two-bit level histogram: sample words in, level counts out.
`default_nettype none
module tb_two_bit_level_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	import tbh_pkg::*;

	// Stop the run here if the block hangs: worst case is every word dumping
	// 64 counts against a receiver that stalls on each.
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	// Leave margin for the pipeline to settle before touching the register.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD     = 500;
	localparam int unsigned REPORT_MAX    = 10;
	localparam logic [7:0]  LEVEL_MASK    = 8'h03;

	// Register map: index taken from paddr[2]; the second slot is unmapped.
	localparam logic [APB_ADDR_W-1:0] ADDR_STREAM_MODE = {REG_STREAM_MODE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = {~REG_STREAM_MODE, 2'b00};

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	two_bit_level_histogram DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: its stream mode, its 64 level counters and the
	// counts that are owed to the result channel, oldest first.
	// ------------------------------------------------------------------
	stream_mode_t                 mode_now = MODE_2;
	logic [COUNT_WIDTH_DEF-1:0]   level_tally [NUM_CNT];
	result_t                      due_counts [$];
	sample_t                      pending_words [$];

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	// Idle controls, set per phase by the stimulus process.
	logic        send_idle  = 1'b0;
	logic        recv_idle  = 1'b0;
	logic        hold_req   = 1'b0;
	logic        hold_taken = 1'b0;
	int unsigned send_gap   = 0;
	int unsigned recv_gap   = 0;
	int unsigned hold_left  = 0;

	result_t     count_want;

	initial begin
		for (int i = 0; i < NUM_CNT; i++) level_tally[i] = '0;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
	endtask

	// Count one accepted word and, on the period's last word, queue the dump
	// and clear every counter (inactive streams included).
	task automatic tally_word(input sample_t w);
		logic [7:0]  lane [4];
		int unsigned shift;
		int unsigned strm;
		int unsigned lvl;
		int unsigned nstr;
		result_t     r;
		lane[0] = w.byte_0;
		lane[1] = w.byte_1;
		lane[2] = w.byte_2;
		lane[3] = w.byte_3;
		shift   = 3 - int'(mode_now);
		for (int k = 0; k < NUM_LANES; k++) begin
			for (int p = 0; p < FIELDS_PER_LANE; p++) begin
				// fields run most significant first within each byte
				strm = (k * FIELDS_PER_LANE + p) >> shift;
				lvl  = (lane[k] >> (6 - 2 * p)) & LEVEL_MASK;
				if (level_tally[strm * NUM_LEVELS + lvl] != '1)
					level_tally[strm * NUM_LEVELS + lvl]++;
			end
		end
		if (w.end_of_period) begin
			nstr = 2 << int'(mode_now);
			for (int s = 0; s < nstr; s++) begin
				for (int l = 0; l < NUM_LEVELS; l++) begin
					r.stream_index = s[3:0];
					r.level        = l[1:0];
					r.count        = level_tally[s * NUM_LEVELS + l];
					r.last_of_dump = (s == nstr - 1) && (l[1:0] == LEVEL_TOP);
					due_counts.push_back(r);
				end
			end
			for (int i = 0; i < NUM_CNT; i++) level_tally[i] = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Sample driver: present the next pending word, hold it until taken,
	// and drop in random idle bursts when enabled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) tally_word(sample);
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					sample       <= pending_words.pop_front();
					sample_valid <= 1'b1;
					if (send_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: one long hold-off on request, otherwise random
	// stall bursts when enabled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (hold_req && !hold_taken) begin
				hold_left  = LONG_HOLD;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (recv_idle && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: match each taken word against the oldest owed count.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_counts.size() == 0) begin
				note_mismatch($sformatf("unexpected result: stream %0d level %0d count %0d last %0b",
					result.stream_index, result.level, result.count, result.last_of_dump));
			end else begin
				count_want = due_counts.pop_front();
				if (result.stream_index !== count_want.stream_index ||
					result.level !== count_want.level ||
					result.count !== count_want.count ||
					result.last_of_dump !== count_want.last_of_dump) begin
					note_mismatch($sformatf(
						"result mismatch: want s%0d l%0d c%0d last %0b, got s%0d l%0d c%0d last %0b",
						count_want.stream_index, count_want.level, count_want.count,
						count_want.last_of_dump, result.stream_index, result.level,
						result.count, result.last_of_dump));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_two_bit_level_histogram: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_word(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic eop);
		sample_t w;
		w.byte_0        = b0;
		w.byte_1        = b1;
		w.byte_2        = b2;
		w.byte_3        = b3;
		w.end_of_period = eop;
		pending_words.push_back(w);
	endtask

	// Mix of random words, single-level words and words whose bytes 0 and 2 hold a single level.
	task automatic push_random(input int unsigned eop_odds);
		logic [1:0]  lvl;
		logic [7:0]  b;
		logic [31:0] bits;
		logic        eop;
		lvl  = 2'($urandom_range(0, 3));
		b    = {4{lvl}};
		bits = $urandom;
		eop  = ($urandom_range(1, eop_odds) == 1);
		case ($urandom_range(0, 9))
			0: push_word(b, b, b, b, eop);
			1: push_word(b, bits[7:0], b, bits[15:8], eop);
			default: push_word(bits[7:0], bits[15:8], bits[23:16], bits[31:24], eop);
		endcase
	endtask

	// Wait until the sender has nothing left and every owed count has come,
	// then let the pipeline settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || sample_valid || due_counts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_STREAM_MODE) mode_now = stream_mode_t'(data[1:0]);
	endtask

	// Read the mode register back and compare with the shadow copy.
	task automatic check_mode_reg();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_STREAM_MODE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(mode_now))
			note_mismatch($sformatf("stream_mode readback: want %0d, got %0h", mode_now, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_mode(input stream_mode_t m);
		wait_idle();
		reg_write(ADDR_STREAM_MODE, APB_DATA_W'(m));
		check_mode_reg();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		stream_mode_t phase_modes [8];
		phase_modes = '{MODE_16, MODE_2, MODE_8, MODE_4, MODE_16, MODE_2, MODE_4, MODE_8};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset mode is two streams; extremes of the word first.
		push_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_word(8'h1B, 8'hE4, 8'h55, 8'hAA, 1'b1);

		// Write to the unmapped slot: mode must stay at two streams.
		wait_idle();
		reg_write(ADDR_UNMAPPED, APB_DATA_W'(MODE_16));
		check_mode_reg();
		push_word(8'h1B, 8'hE4, 8'h00, 8'hFF, 1'b1);

		// Every mode once, with all four levels spread over the fields.
		set_mode(MODE_4);
		push_word(8'h1B, 8'hE4, 8'h55, 8'hAA, 1'b1);
		set_mode(MODE_8);
		push_word(8'h1E, 8'hB4, 8'hC3, 8'h69, 1'b0);
		push_word(8'h1E, 8'hB4, 8'hC3, 8'h69, 1'b1);
		set_mode(MODE_16);
		push_word(8'h1B, 8'hE4, 8'h55, 8'hAA, 1'b0);
		push_word(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);

		// Mode change within a period: sixteen-stream counts go unreported
		// for streams 2..15 but must still be cleared by the dump.
		push_word(8'hE4, 8'h1B, 8'hAA, 8'h55, 1'b0);
		push_word(8'h39, 8'hC6, 8'h0F, 8'hF0, 1'b0);
		set_mode(MODE_2);
		push_word(8'h00, 8'h55, 8'hAA, 8'hFF, 1'b1);
		set_mode(MODE_16);
		push_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);

		// Random phases, one mode each, idling varied per phase.
		for (int ph = 0; ph < 8; ph++) begin
			set_mode(phase_modes[ph]);
			send_idle = (ph % 3 != 2);
			recv_idle = (ph % 4 != 3);
			for (int i = 0; i < 40; i++) push_random(8);
			// even phases close the period; odd phases may carry open counters into the next mode
			if (ph % 2 == 0) push_random(1);
		end

		// Backpressure: hold the receiver off while back-to-back dumps keep
		// coming, so the block fills up and stalls the sample side.
		set_mode(MODE_16);
		send_idle = 1'b0;
		recv_idle = 1'b1;
		hold_req  = 1'b1;
		for (int i = 0; i < 30; i++) push_random((i % 3 == 2) ? 1 : 16);
		push_word(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);

		// Final stretch: no idling on either side.
		set_mode(MODE_8);
		recv_idle = 1'b0;
		recv_gap  = 0;
		for (int i = 0; i < 30; i++) push_random(6);
		push_random(1);

		wait_idle();
		if (mismatches == 0 && due_counts.size() == 0) begin
			$display("tb_two_bit_level_histogram: PASS");
		end else begin
			$display("tb_two_bit_level_histogram: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/tbh_pkg.sv
hdl/tbh_lane.sv
hdl/tbh_merge.sv
hdl/tbh_counters.sv
hdl/tbh_dump.sv
hdl/two_bit_level_histogram.sv
tb/sv/tb_two_bit_level_histogram.sv
